// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GPE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion violated");

// next-cycle implication
`define GPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

// ===== rtl/gpe_pkg.sv =====
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared types, constants and class predicates for the erosion unit.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 1024;
  localparam int WIN        = 5;
  localparam int LINES      = WIN - 1;
  localparam int CLASS_W    = 4;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int GW_W       = 9;
  localparam int GH_W       = 11;
  localparam int CFG_DATA_W = GH_W;
  localparam int LINE_W     = LINES * CLASS_W;

  localparam logic [GW_W-1:0] GW_RESET = GW_W'(256);
  localparam logic [GH_W-1:0] GH_RESET = GH_W'(1024);
  localparam logic [GW_W-1:0] GW_MAX   = GW_W'(MAX_WIDTH);
  localparam logic [GH_W-1:0] GH_MAX   = GH_W'(MAX_HEIGHT);

  typedef logic [CLASS_W-1:0] cell_t;

  localparam cell_t CLS_EMPTY     = 4'd0;
  localparam cell_t CLS_PASSABLE  = 4'd1;
  localparam cell_t CLS_HOMEBASE  = 4'd2;
  localparam cell_t CLS_OUT       = 4'd3;
  localparam cell_t CLS_WALL      = 4'd4;
  localparam cell_t CLS_STACK0    = 4'd5;
  localparam cell_t CLS_STACK3    = 4'd8;
  localparam cell_t CLS_OWN_STACK = 4'd9;
  localparam cell_t CLS_NOMAN     = 4'd10;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_GRID_WIDTH  = 1'b0;
  localparam reg_idx_t REG_GRID_HEIGHT = 1'b1;

  // cell as seen at acceptance, positions of the incoming cell
  typedef struct packed {
    logic             full;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    cell_t            cls;
    logic             frame_end;
  } scan_t;

  typedef struct packed {
    logic             center_valid;
    logic [COL_W-1:0] center_x;
    logic [ROW_W-1:0] center_y;
    logic             passable;
    cell_t            center_class;
    logic             frame_end;
  } result_t;

  function automatic logic is_ground(input cell_t c);
    return c inside {CLS_EMPTY, CLS_PASSABLE, CLS_HOMEBASE, CLS_NOMAN};
  endfunction

  function automatic logic cell_ok(input cell_t c);
    return is_ground(c) || (c inside {[CLS_STACK0:CLS_STACK3]});
  endfunction

endpackage

// ===== rtl/gpe_ram.sv =====
// ----------------------------------------------------------------------------
// gpe_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module gpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gpe_scan.sv =====
// ----------------------------------------------------------------------------
// gpe_scan
// Size registers and raster position counters.
// ----------------------------------------------------------------------------
module gpe_scan
  import gpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  reg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  acc,
  input  cell_t                 cell_class,
  output scan_t                 scan
);

  logic [GW_W-1:0]  grid_width;
  logic [GH_W-1:0]  grid_height;
  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;

  logic [GW_W-1:0]  w, x_inc;
  logic [GH_W-1:0]  h, y_raw, y_inc;
  logic             wrap;
  logic [COL_W-1:0] x;
  logic [ROW_W-1:0] y;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GW_RESET;
      grid_height <= GH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[GW_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[GH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w = (grid_width == '0) ? GW_W'(1) : ((grid_width > GW_MAX) ? GW_MAX : grid_width);
    h = (grid_height == '0) ? GH_W'(1) : ((grid_height > GH_MAX) ? GH_MAX : grid_height);

    wrap  = {1'b0, column_count} >= w;
    x     = wrap ? '0 : column_count;
    y_raw = wrap ? ({1'b0, row_count} + GH_W'(1)) : {1'b0, row_count};
    y     = (y_raw >= h) ? '0 : y_raw[ROW_W-1:0];

    x_inc = {1'b0, x} + GW_W'(1);
    y_inc = {1'b0, y} + GH_W'(1);

    if (x_inc >= w) begin
      column_count_next = '0;
      row_count_next    = (y_inc >= h) ? '0 : y_inc[ROW_W-1:0];
    end else begin
      column_count_next = x_inc[COL_W-1:0];
      row_count_next    = y;
    end

    scan.full      = (x >= COL_W'(WIN - 1)) && (y >= ROW_W'(WIN - 1));
    scan.x         = x;
    scan.y         = y;
    scan.cls       = cell_class;
    scan.frame_end = (x_inc == w) && (y_inc == h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// ===== rtl/gpe_window.sv =====
// ----------------------------------------------------------------------------
// gpe_window
// Line buffer read-modify-write, 5x5 window shift and erosion judgement.
// ----------------------------------------------------------------------------
module gpe_window
  import gpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    acc,
  input  scan_t   scan,
  output logic    res_valid,
  output result_t res
);

  `include "assert_macros.svh"

  scan_t             s1;
  logic              s1_valid;
  logic              fwd_hit;
  logic [LINE_W-1:0] fwd_data;
  logic [LINE_W-1:0] ram_rdata, lines, wdata;
  cell_t             col [WIN];
  cell_t             win [WIN][WIN];
  cell_t             win_next [WIN][WIN];
  cell_t             ctr;
  logic              all_ok, pass;

  // line k of the packed word holds row y-1-k
  gpe_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1.x),
    .wdata(wdata),
    .re   (acc),
    .raddr(scan.x),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= acc;
      fwd_hit  <= acc && s1_valid && (s1.x == scan.x);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1       <= scan;
      fwd_data <= wdata;
    end
  end

  always_comb begin
    lines = fwd_hit ? fwd_data : ram_rdata;
    wdata = {lines[LINE_W-CLASS_W-1:0], s1.cls};
    for (int r = 0; r < LINES; r++) begin
      col[r] = lines[(LINES-1-r)*CLASS_W +: CLASS_W];
    end
    col[WIN-1] = s1.cls;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) begin
        win_next[r][c] = win[r][c+1];
      end
      win_next[r][WIN-1] = col[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          win[r][c] <= CLS_EMPTY;
        end
      end
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  always_comb begin
    ctr    = win_next[WIN/2][WIN/2];
    all_ok = 1'b1;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN; c++) begin
        all_ok = all_ok & cell_ok(win_next[r][c]);
      end
    end
    pass = s1.full && is_ground(ctr) && all_ok;

    res_valid        = s1_valid;
    res.center_valid = s1.full;
    res.center_x     = s1.full ? (s1.x - COL_W'(WIN/2)) : '0;
    res.center_y     = s1.full ? (s1.y - ROW_W'(WIN/2)) : '0;
    res.passable     = pass;
    res.frame_end    = s1.frame_end;
    if (!s1.full) begin
      res.center_class = CLS_EMPTY;
    end else if (pass) begin
      res.center_class = CLS_PASSABLE;
    end else if (ctr == CLS_PASSABLE) begin
      res.center_class = CLS_EMPTY;
    end else begin
      res.center_class = ctr;
    end
  end

  `GPE_ASSERT_IMPL(a_fwd_in_flight, fwd_hit, s1_valid)

endmodule

// ===== rtl/gpe_out_buf.sv =====
// ----------------------------------------------------------------------------
// gpe_out_buf
// Two-entry result queue; stalls the input side on in-flight occupancy.
// ----------------------------------------------------------------------------
module gpe_out_buf
  import gpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t head,
  output logic    in_stall
);

  `include "assert_macros.svh"

  result_t    entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;
  logic [2:0] level;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = entry[rd_ptr];
  // the transfer in flight in the window stage always lands next cycle
  assign level     = {1'b0, count} + {2'b00, push};
  assign in_stall  = level >= (3'd2 + {2'b00, pop});

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `GPE_ASSERT_IMPL(a_count_range, 1'b1, count <= 2'd2)
  `GPE_ASSERT_IMPL(a_no_overflow, push, (count < 2'd2) || pop)

endmodule

// ===== rtl/grid_passable_erosion_unit.sv =====
// ----------------------------------------------------------------------------
// grid_passable_erosion_unit
// Streaming 5x5 erosion of occupancy-grid classes over a raster stream.
// ----------------------------------------------------------------------------
// Takes one cell class per clock in raster order while in_stall is low and
// returns one result per cell: each input is registered in the window stage
// and its result in the output queue. The line-buffer RAM (MAX_WIDTH x 16
// bits, four packed lines) sets the rate, is read once and written back once
// per cell and is not cleared at reset; back-to-back reads of the same column
// are forwarded. Edge rows never use unwritten entries within a frame. The
// user writes size registers only while the unit is idle; it is not enforced.
module grid_passable_erosion_unit
  import gpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  reg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cell_t                 cell_class,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  center_valid,
  output logic [COL_W-1:0]      center_x,
  output logic [ROW_W-1:0]      center_y,
  output logic                  passable,
  output cell_t                 center_class,
  output logic                  frame_end
);

  `include "assert_macros.svh"

  logic    acc;
  scan_t   scan;
  logic    res_valid;
  result_t res, head;

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && !in_stall;

  gpe_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .cell_class(cell_class),
    .scan      (scan)
  );

  gpe_window u_window (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .scan     (scan),
    .res_valid(res_valid),
    .res      (res)
  );

  gpe_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_data(res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .head     (head),
    .in_stall (in_stall)
  );

  assign center_valid = head.center_valid;
  assign center_x     = head.center_x;
  assign center_y     = head.center_y;
  assign passable     = head.passable;
  assign center_class = head.center_class;
  assign frame_end    = head.frame_end;

  `GPE_ASSERT_IMPL(a_pass_class, out_valid && passable, center_class == CLS_PASSABLE)
  `GPE_ASSERT_IMPL(a_edge_quiet, out_valid && !center_valid,
                   !passable && (center_class == CLS_EMPTY))

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for grid_passable_erosion_unit. Cell classes are streamed
// in raster order, frame by frame, with random valid/stall gaps. A local
// erosion predictor follows each accepted transfer, and every result transfer
// is checked against the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;
  import gpe_pkg::*;

  localparam int unsigned RUN_LIMIT    = 250000;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned TAIL_CYCLES  = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  reg_idx_t              cfg_index = REG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cell_t                 cell_class = CLS_EMPTY;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  center_valid;
  logic [COL_W-1:0]      center_x;
  logic [ROW_W-1:0]      center_y;
  logic                  passable;
  cell_t                 center_class;
  logic                  frame_end;

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatch_count = 0;

  // predictor state
  logic [GW_W-1:0] width_reg  = GW_RESET;
  logic [GH_W-1:0] height_reg = GH_RESET;
  cell_t           line_hist [LINES][MAX_WIDTH] = '{default: '0};
  cell_t           window_buf [WIN][WIN] = '{default: '0};
  int unsigned     col_cnt = 0;
  int unsigned     row_cnt = 0;
  result_t         expected_results [$];

  grid_passable_erosion_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cell_class   (cell_class),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .center_valid (center_valid),
    .center_x     (center_x),
    .center_y     (center_y),
    .passable     (passable),
    .center_class (center_class),
    .frame_end    (frame_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  function automatic logic is_floor(input cell_t c);
    return c == CLS_EMPTY || c == CLS_PASSABLE || c == CLS_HOMEBASE || c == CLS_NOMAN;
  endfunction

  function automatic logic is_pickup(input cell_t c);
    return c >= CLS_STACK0 && c <= CLS_STACK3;
  endfunction

  // advance the raster position by one cell and judge the window centre
  function automatic result_t erode_cell(input cell_t c);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    cell_t       column [WIN];
    logic        fits;
    result_t     res;
    w = clamp_dim(32'(width_reg), MAX_WIDTH);
    h = clamp_dim(32'(height_reg), MAX_HEIGHT);
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    x = col_cnt;
    y = row_cnt;
    for (int i = 0; i < LINES; i++) column[i] = line_hist[LINES-1-i][x];
    column[WIN-1] = c;
    for (int i = LINES - 1; i > 0; i--) line_hist[i][x] = line_hist[i-1][x];
    line_hist[0][x] = c;
    for (int r = 0; r < WIN; r++) begin
      for (int k = 0; k < WIN - 1; k++) window_buf[r][k] = window_buf[r][k+1];
      window_buf[r][WIN-1] = column[r];
    end
    res = '0;
    if (x >= 4 && y >= 4) begin
      res.center_valid = 1'b1;
      res.center_x     = COL_W'(x - 2);
      res.center_y     = ROW_W'(y - 2);
      fits = is_floor(window_buf[2][2]);
      for (int r = 0; r < WIN; r++)
        for (int k = 0; k < WIN; k++)
          if (!(is_floor(window_buf[r][k]) || is_pickup(window_buf[r][k]))) fits = 1'b0;
      res.passable = fits;
      if (fits) res.center_class = CLS_PASSABLE;
      else if (window_buf[2][2] == CLS_PASSABLE) res.center_class = CLS_EMPTY;
      else res.center_class = window_buf[2][2];
    end
    res.frame_end = (x == w - 1) && (y == h - 1);
    col_cnt = x + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = y + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    return res;
  endfunction

  // result transfer checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {center_valid, center_x, center_y, passable, center_class, frame_end};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: valid=%0b x=%0d y=%0d pass=%0b class=%0d end=%0b",
                   got.center_valid, got.center_x, got.center_y, got.passable,
                   got.center_class, got.frame_end);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp valid=%0b x=%0d y=%0d pass=%0b class=%0d end=%0b",
                     want.center_valid, want.center_x, want.center_y, want.passable,
                     want.center_class, want.frame_end);
            $display("          got valid=%0b x=%0d y=%0d pass=%0b class=%0d end=%0b",
                     got.center_valid, got.center_x, got.center_y, got.passable,
                     got.center_class, got.frame_end);
          end
        end
      end
    end
  end

  task automatic set_idling(input int unsigned phase);
    case (phase)
      0: begin
        in_idle_pct   = 30;
        out_stall_pct = 64;
      end
      1: begin
        in_idle_pct   = 64;
        out_stall_pct = 30;
      end
      default: begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_cell(input cell_t c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cell_class <= c;
    do @(posedge clk); while (in_stall);
    expected_results.insert(expected_results.size(), erode_cell(c));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // writes both size registers, unit must be idle
  task automatic set_grid(input int unsigned w_val, input int unsigned h_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= CFG_DATA_W'(w_val);
    do @(posedge clk); while (!cfg_ready);
    width_reg = GW_W'(w_val);
    @(negedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h_val);
    do @(posedge clk); while (!cfg_ready);
    height_reg = GH_W'(h_val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // noisy = 0: mostly ground and stacks, rare obstacles
  function automatic cell_t pick_cell(input logic noisy);
    int unsigned roll;
    if (noisy) return cell_t'($urandom_range(15));
    roll = $urandom_range(99);
    if (roll < 60) begin
      case ($urandom_range(3))
        0: return CLS_EMPTY;
        1: return CLS_PASSABLE;
        2: return CLS_HOMEBASE;
        default: return CLS_NOMAN;
      endcase
    end
    if (roll < 97) return cell_t'(CLS_STACK0 + $urandom_range(3));
    return cell_t'($urandom_range(15));
  endfunction

  function automatic logic at_frame_start();
    return col_cnt == 0 && row_cnt == 0;
  endfunction

  task automatic test_tiny_grids();
    set_idling(0);
    drain();
    set_grid(0, 0);
    for (int i = 0; i < 3; i++) send_cell(CLS_WALL);
    drain();
    set_grid(4, 4);
    for (int i = 0; i < 16; i++) send_cell(cell_t'(i));
    drain();
    set_grid(1, 6);
    for (int i = 0; i < 6; i++) send_cell(CLS_OWN_STACK);
  endtask

  // class k sits at column 2 of row k+2, neighbours are ground or stacks
  task automatic test_class_codes();
    cell_t c;
    set_idling(1);
    drain();
    set_grid(5, 20);
    for (int row = 0; row < 20; row++)
      for (int col = 0; col < 5; col++) begin
        if (col == 2 && row >= 2 && row < 18) c = cell_t'(row - 2);
        else begin
          case ((row + col) % 8)
            0: c = CLS_EMPTY;
            1: c = CLS_PASSABLE;
            2: c = CLS_HOMEBASE;
            3: c = CLS_NOMAN;
            default: c = cell_t'(CLS_STACK0 + (row + col) % 8 - 4);
          endcase
        end
        send_cell(c);
      end
  endtask

  // oversize width saturates: one full row of the widest grid
  task automatic test_size_extremes();
    set_idling(2);
    drain();
    set_grid(11'h7FF, 1);
    do send_cell(pick_cell(1'b0)); while (!at_frame_start());
  endtask

  // shrink width and height mid-frame so the counters land past the new size
  task automatic test_mid_frame_shrink();
    set_idling(1);
    drain();
    set_grid(8, 12);
    for (int i = 0; i < 6 * 8 + 6; i++) send_cell(pick_cell(1'b0));
    drain();
    set_grid(6, 12);
    for (int i = 0; i < 2 * 6 + 2; i++) send_cell(pick_cell(1'b0));
    drain();
    set_grid(6, 5);
    do send_cell(pick_cell(1'b0)); while (!at_frame_start());
  endtask

  task automatic test_random_frames();
    int unsigned items;
    int unsigned w;
    int unsigned h;
    logic        noisy;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      set_idling(items * 3 / RANDOM_ITEMS);
      drain();
      if ($urandom_range(7) == 0) begin
        w = $urandom_range(4);
        h = $urandom_range(4);
      end else begin
        w = $urandom_range(12, 5);
        h = $urandom_range(10, 5);
      end
      set_grid(w, h);
      noisy = ($urandom_range(3) == 0);
      do begin
        send_cell(pick_cell(noisy));
        items++;
        // width may only shrink mid-frame so line data stays current
        if (!at_frame_start() && row_cnt >= 4 && $urandom_range(29) == 0) begin
          w = clamp_dim(32'(width_reg), MAX_WIDTH);
          drain();
          set_grid($urandom_range(w, 1), $urandom_range(10, 1));
        end
      end while (!at_frame_start());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_tiny_grids();
    test_class_codes();
    test_size_extremes();
    test_mid_frame_shrink();
    test_random_frames();
    set_idling(2);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gpe_pkg.sv
rtl/gpe_ram.sv
rtl/gpe_scan.sv
rtl/gpe_window.sv
rtl/gpe_out_buf.sv
rtl/grid_passable_erosion_unit.sv
test/testbench.sv
